// ----- hdl/mbsp_pkg.sv -----
// Package for the MIDI byte stream parser: status byte codes, the result
// word type, the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package mbsp_pkg;

  localparam int SysexDepthDefault = 64;

  // Status byte codes
  localparam logic [7:0] MIDI_RT_MIN      = 8'hF8;
  localparam logic [7:0] MIDI_SYSEX_START = 8'hF0;
  localparam logic [7:0] MIDI_SYSEX_END   = 8'hF7;
  localparam logic [7:0] MIDI_CH_MIN      = 8'h80;
  localparam logic [7:0] MIDI_CH_MAX      = 8'hE0;
  localparam logic [7:0] MIDI_PROG_CHANGE = 8'hC0;
  localparam logic [7:0] MIDI_CH_PRESSURE = 8'hD0;
  localparam logic [7:0] MIDI_TIME_CODE   = 8'hF1;
  localparam logic [7:0] MIDI_SONG_SELECT = 8'hF3;
  localparam logic [7:0] MIDI_SONG_POS    = 8'hF2;
  localparam logic [7:0] MIDI_TUNE_REQ    = 8'hF6;

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_SYSEX = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PUSH
  } mbsp_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] status_byte;
    logic [6:0] data_first;
    logic [6:0] data_second;
    logic [7:0] sysex_byte;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic accept;     // take the input word and update parse state
    logic rd_en;      // read store at the dump index
    logic dump_push;  // queue the read store byte
    logic idx_inc;    // advance dump index
  } cmd_t;

  typedef struct packed {
    logic fifo_full;
    logic dump_start; // input word is an F7 closing a SysEx that fits
    logic dump_last;  // dump index is at the F7
  } sts_t;

  // Number of data bytes that follow a status byte
  function automatic logic [1:0] data_count(input logic [7:0] st);
    logic [7:0] hi;
    hi = {st[7:4], 4'h0};
    if (hi >= MIDI_CH_MIN && hi <= MIDI_CH_MAX) begin
      data_count = (hi == MIDI_PROG_CHANGE || hi == MIDI_CH_PRESSURE) ? 2'd1 : 2'd2;
    end else if (st == MIDI_TIME_CODE || st == MIDI_SONG_SELECT) begin
      data_count = 2'd1;
    end else if (st == MIDI_SONG_POS) begin
      data_count = 2'd2;
    end else begin
      data_count = 2'd0;
    end
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mbsp_ctrl.sv -----
// Controller for the MIDI byte stream parser: accepts input words and
// sequences the SysEx store readout. Depends on mbsp_pkg.
`default_nettype none

module mbsp_ctrl
  import mbsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  mbsp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = sts.fifo_full;
        cmd.accept = in_valid && !sts.fifo_full;
        if (cmd.accept && sts.dump_start) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!sts.fifo_full) begin
          cmd.dump_push = 1'b1;
          if (sts.dump_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/mbsp_datapath.sv -----
// Datapath for the MIDI byte stream parser: running status registers,
// SysEx store, and a two-word output queue. Depends on mbsp_pkg.
`default_nettype none

module mbsp_datapath
  import mbsp_pkg::*;
#(
  parameter int SYSEX_DEPTH = SysexDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] midi_byte,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  output logic            out_valid,
  input  wire logic       out_stall,
  output result_t         out_res
);

  localparam int LW = $clog2(SYSEX_DEPTH + 1);
  localparam int AW = $clog2(SYSEX_DEPTH);

  logic [7:0]    running_status;
  logic [1:0]    needed_count;
  logic          held_count;
  logic [6:0]    held_first;
  logic          in_sysex;
  logic [LW-1:0] sysex_length;

  logic [7:0]    sysex_store [SYSEX_DEPTH];
  logic [7:0]    store_q;
  logic [AW-1:0] idx;
  logic [AW-1:0] last_idx;

  logic          len_room;
  logic          is_status;
  logic          store_we;
  logic [AW-1:0] store_wa;

  logic          short_push;
  result_t       short_res;
  result_t       dump_res;
  result_t       push_res;
  logic          push;
  logic          pop;

  result_t       fifo_data [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign len_room  = sysex_length < LW'(SYSEX_DEPTH);
  assign is_status = midi_byte[7];

  assign sts.fifo_full  = count == 2'd2;
  assign sts.dump_start = midi_byte == MIDI_SYSEX_END && in_sysex && len_room;
  assign sts.dump_last  = idx == last_idx;

  // Short message decode for the incoming word
  always_comb begin
    short_push            = 1'b0;
    short_res             = '0;
    short_res.kind        = KIND_SHORT;
    short_res.last_of_run = 1'b1;
    if (cmd.accept) begin
      if (midi_byte >= MIDI_RT_MIN) begin
        short_push            = 1'b1;
        short_res.status_byte = midi_byte;
      end else if (is_status) begin
        if (midi_byte != MIDI_SYSEX_START && midi_byte != MIDI_SYSEX_END &&
            data_count(midi_byte) == 2'd0) begin
          short_push            = 1'b1;
          short_res.status_byte = midi_byte;
        end
      end else if (!in_sysex && needed_count != 2'd0 && running_status != 8'd0) begin
        short_res.status_byte = running_status;
        if (!held_count) begin
          if (needed_count == 2'd1) begin
            short_push           = 1'b1;
            short_res.data_first = midi_byte[6:0];
          end
        end else begin
          short_push            = 1'b1;
          short_res.data_first  = held_first;
          short_res.data_second = midi_byte[6:0];
        end
      end
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_status <= '0;
      needed_count   <= '0;
      held_count     <= 1'b0;
      in_sysex       <= 1'b0;
      sysex_length   <= '0;
    end else if (cmd.accept) begin
      if (midi_byte >= MIDI_RT_MIN) begin
        // real-time: no state change
      end else if (midi_byte == MIDI_SYSEX_START) begin
        in_sysex       <= 1'b1;
        running_status <= '0;
        needed_count   <= '0;
        held_count     <= 1'b0;
        sysex_length   <= LW'(1);
      end else if (midi_byte == MIDI_SYSEX_END) begin
        in_sysex     <= 1'b0;
        sysex_length <= '0;
      end else if (is_status) begin
        in_sysex       <= 1'b0;
        sysex_length   <= '0;
        running_status <= midi_byte;
        needed_count   <= data_count(midi_byte);
        held_count     <= 1'b0;
      end else if (in_sysex) begin
        if (len_room) begin
          sysex_length <= sysex_length + LW'(1);
        end else begin
          // overflow drops the whole SysEx
          sysex_length <= '0;
          in_sysex     <= 1'b0;
        end
      end else if (needed_count != 2'd0 && running_status != 8'd0) begin
        if (!held_count) begin
          if (needed_count == 2'd2) begin
            held_count <= 1'b1;
          end
        end else begin
          held_count <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !is_status && !in_sysex && !held_count) begin
      held_first <= midi_byte[6:0];
    end
  end

  // SysEx store
  assign store_we = cmd.accept &&
                    (midi_byte == MIDI_SYSEX_START ||
                     (midi_byte == MIDI_SYSEX_END && in_sysex && len_room) ||
                     (!is_status && in_sysex && len_room));
  assign store_wa = (midi_byte == MIDI_SYSEX_START) ? '0 : sysex_length[AW-1:0];

  always_ff @(posedge clk) begin
    if (store_we) begin
      sysex_store[store_wa] <= midi_byte;
    end
    if (cmd.rd_en) begin
      store_q <= sysex_store[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.dump_start) begin
      last_idx <= sysex_length[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.accept) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end
  end

  always_comb begin
    dump_res             = '0;
    dump_res.kind        = KIND_SYSEX;
    dump_res.sysex_byte  = store_q;
    dump_res.last_of_run = sts.dump_last;
  end

  // Output queue, two words deep
  assign push     = short_push || cmd.dump_push;
  assign push_res = cmd.dump_push ? dump_res : short_res;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_data[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_valid = count != 2'd0;
  assign out_res   = fifo_data[rd_ptr];

endmodule

`default_nettype wire

// ----- hdl/midi_byte_stream_parser.sv -----
// MIDI byte stream parser, top level. Joins mbsp_ctrl and mbsp_datapath.
// Depends on mbsp_pkg.
//
// Usage: one raw MIDI byte per input word on midi_byte with in_valid /
// in_stall; one result per output word with out_valid / out_stall.
// A word moves at a clock edge where valid is high and stall is low.
// Short messages (real-time, completed channel or system-common messages,
// data-less status) are written to the output queue as the byte that
// completes them is taken. Bytes that complete nothing give no output.
// Ordinary bytes are taken one per cycle while the two-word output queue
// has room. An F7 that closes a stored SysEx starts a readout: the input
// stalls while the store is read back, each stored byte, F0 and F7
// included, going through a read state and then a push state (one store
// read port, registered read data); a push waits while the queue is full.
// last_of_run marks the final word of each input byte's results.
// Reset clears running status and SysEx state and empties the queue.
// While out_stall is high the head word holds; once the queue is full
// in_stall rises and input waits. No clearing pass is needed after reset.
`default_nettype none

module midi_byte_stream_parser
  import mbsp_pkg::*;
#(
  parameter int SYSEX_DEPTH = SysexDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] midi_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            kind,
  output logic [7:0]      status_byte,
  output logic [6:0]      data_first,
  output logic [6:0]      data_second,
  output logic [7:0]      sysex_byte,
  output logic            last_of_run
);

  cmd_t    cmd;
  sts_t    sts;
  result_t out_res;

  mbsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbsp_datapath #(
    .SYSEX_DEPTH (SYSEX_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .midi_byte (midi_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign kind        = out_res.kind;
  assign status_byte = out_res.status_byte;
  assign data_first  = out_res.data_first;
  assign data_second = out_res.data_second;
  assign sysex_byte  = out_res.sysex_byte;
  assign last_of_run = out_res.last_of_run;

endmodule

`default_nettype wire

// ----- test/midi_byte_stream_parser_test.sv -----
// Self-checking testbench for midi_byte_stream_parser: drives raw MIDI bytes,
// predicts short messages and SysEx byte runs, checks every output word in order.
// Depends on mbsp_pkg and the parser RTL.
`timescale 1ns / 1ps

module midi_byte_stream_parser_test
  import mbsp_pkg::*;
();

  localparam int SX_DEPTH = SysexDepthDefault;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_SHOWN = 10;
  localparam int DRAIN_LIMIT = 50000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [7:0] UNDEF_COMMON_A = 8'hF4;
  localparam logic [7:0] UNDEF_COMMON_B = 8'hF5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] midi_byte = 8'h00;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic kind;
  logic [7:0] status_byte;
  logic [6:0] data_first;
  logic [6:0] data_second;
  logic [7:0] sysex_byte;
  logic last_of_run;

  // parser state as seen by the predictor
  logic [7:0] cur_status = 8'h00;
  logic [1:0] data_needed = 2'd0;
  logic have_first = 1'b0;
  logic [6:0] first_data = 7'h00;
  logic sysex_open = 1'b0;
  int sx_len = 0;
  logic [7:0] sx_buf [SX_DEPTH];

  result_t parsed_words[$];
  int errors = 0;
  int bytes_sent = 0;
  int bytes_effective = 0;
  int short_words = 0;
  int sysex_words = 0;
  int sysex_runs = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int burst_left = 0;

  midi_byte_stream_parser #(
    .SYSEX_DEPTH(SX_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .midi_byte(midi_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .status_byte(status_byte),
    .data_first(data_first),
    .data_second(data_second),
    .sysex_byte(sysex_byte),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [1:0] bytes_after(input logic [7:0] s);
    if (s[7:4] == MIDI_PROG_CHANGE[7:4] || s[7:4] == MIDI_CH_PRESSURE[7:4]) return 2'd1;
    if (s >= MIDI_CH_MIN && s < MIDI_SYSEX_START) return 2'd2;
    if (s == MIDI_TIME_CODE || s == MIDI_SONG_SELECT) return 2'd1;
    if (s == MIDI_SONG_POS) return 2'd2;
    return 2'd0;
  endfunction

  function automatic void queue_word(input logic k, input logic [7:0] st, input logic [6:0] d1,
                                     input logic [6:0] d2, input logic [7:0] sx,
                                     input logic last);
    result_t w;
    w.kind = k;
    w.status_byte = st;
    w.data_first = d1;
    w.data_second = d2;
    w.sysex_byte = sx;
    w.last_of_run = last;
    parsed_words.push_back(w);
  endfunction

  // took is low for bytes the parser drops without any state change
  task automatic parse_byte(input logic [7:0] b, output bit took);
    int i;
    took = 1'b1;
    if (b >= MIDI_RT_MIN) begin
      queue_word(KIND_SHORT, b, 7'h00, 7'h00, 8'h00, 1'b1);
    end else if (b[7]) begin
      if (b == MIDI_SYSEX_START) begin
        sysex_open = 1'b1;
        cur_status = 8'h00;
        data_needed = 2'd0;
        have_first = 1'b0;
        sx_buf[0] = b;
        sx_len = 1;
      end else if (b == MIDI_SYSEX_END) begin
        if (!sysex_open) begin
          took = 1'b0;
        end else if (sx_len < SX_DEPTH) begin
          sx_buf[sx_len] = b;
          sx_len++;
          for (i = 0; i < sx_len; i++) begin
            queue_word(KIND_SYSEX, 8'h00, 7'h00, 7'h00, sx_buf[i], i == sx_len - 1);
          end
          sysex_runs++;
        end
        sysex_open = 1'b0;
        sx_len = 0;
      end else begin
        // any other status aborts a SysEx in progress silently
        sysex_open = 1'b0;
        sx_len = 0;
        cur_status = b;
        data_needed = bytes_after(b);
        have_first = 1'b0;
        if (data_needed == 2'd0) queue_word(KIND_SHORT, b, 7'h00, 7'h00, 8'h00, 1'b1);
      end
    end else if (sysex_open) begin
      if (sx_len < SX_DEPTH) begin
        sx_buf[sx_len] = b;
        sx_len++;
      end else begin
        sysex_open = 1'b0;
        sx_len = 0;
      end
    end else if (cur_status == 8'h00 || data_needed == 2'd0) begin
      took = 1'b0;
    end else if (!have_first) begin
      if (data_needed == 2'd1) begin
        queue_word(KIND_SHORT, cur_status, b[6:0], 7'h00, 8'h00, 1'b1);
      end else begin
        first_data = b[6:0];
        have_first = 1'b1;
      end
    end else begin
      have_first = 1'b0;
      queue_word(KIND_SHORT, cur_status, first_data, b[6:0], 8'h00, 1'b1);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    bit took;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    midi_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    parse_byte(b, took);
    bytes_sent++;
    if (took) bytes_effective++;
  endtask

  task automatic send_data();
    send_byte(8'($urandom_range(0, 127)));
  endtask

  task automatic send_real_time();
    send_byte(MIDI_RT_MIN + 8'($urandom_range(0, 7)));
  endtask

  task automatic channel_msg(input int reps);
    logic [7:0] st;
    int r;
    int k;
    st = MIDI_CH_MIN + 8'($urandom_range(0, 6) * 16) + 8'($urandom_range(0, 15));
    send_byte(st);
    for (r = 0; r < reps; r++) begin
      for (k = 0; k < bytes_after(st); k++) begin
        if ($urandom_range(0, 7) == 0) send_real_time();
        send_data();
      end
    end
  endtask

  task automatic common_msg();
    logic [7:0] st;
    int k;
    case ($urandom_range(0, 5))
      0: st = MIDI_TIME_CODE;
      1: st = MIDI_SONG_POS;
      2: st = MIDI_SONG_SELECT;
      3: st = MIDI_TUNE_REQ;
      4: st = UNDEF_COMMON_A;
      default: st = UNDEF_COMMON_B;
    endcase
    send_byte(st);
    for (k = 0; k < bytes_after(st); k++) send_data();
    if ($urandom_range(0, 3) == 0) send_data();
  endtask

  task automatic sysex_msg(input int len);
    int i;
    send_byte(MIDI_SYSEX_START);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_real_time();
      send_data();
    end
    send_byte(MIDI_SYSEX_END);
  endtask

  task automatic broken_sysex();
    int n;
    int i;
    n = $urandom_range(0, 6);
    send_byte(MIDI_SYSEX_START);
    for (i = 0; i < n; i++) send_data();
    case ($urandom_range(0, 3))
      0: channel_msg(1);
      1: sysex_msg($urandom_range(0, 5));
      2: common_msg();
      default: begin
        send_byte(MIDI_SYSEX_END);
        send_byte(MIDI_SYSEX_END);
      end
    endcase
  endtask

  task automatic random_sequence();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 7) channel_msg($urandom_range(1, 4));
    else if (pick < 9) common_msg();
    else if (pick < 13) sysex_msg($urandom_range(0, 8));
    else if (pick < 14) sysex_msg($urandom_range(9, 40));
    else if (pick < 16) send_real_time();
    else if (pick < 18) send_byte(8'($urandom_range(0, 255)));
    else broken_sysex();
  endtask

  // no running status after reset, F7 with no SysEx open
  task automatic test_orphan_bytes();
    send_byte(8'h00);
    send_byte(MIDI_SYSEX_END);
  endtask

  task automatic test_channel_messages();
    send_byte(MIDI_CH_MIN + 8'h10);
    send_byte(8'h7F);
    send_byte(MIDI_RT_MIN);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(MIDI_PROG_CHANGE + 8'h05);
    send_byte(8'h7F);
  endtask

  task automatic test_system_common();
    send_byte(MIDI_SONG_POS);
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(MIDI_TIME_CODE);
    send_byte(8'h55);
    send_byte(MIDI_TUNE_REQ);
    send_byte(UNDEF_COMMON_A);
    send_byte(8'h7F);
  endtask

  task automatic test_sysex_framing();
    send_byte(MIDI_SYSEX_START);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(MIDI_SYSEX_END);
    // restart mid-SysEx, then an empty one
    send_byte(MIDI_SYSEX_START);
    send_byte(8'h11);
    send_byte(MIDI_SYSEX_START);
    send_byte(MIDI_SYSEX_END);
    // channel status breaks in and is then handled normally
    send_byte(MIDI_SYSEX_START);
    send_byte(8'h22);
    send_byte(MIDI_CH_MIN);
    send_byte(8'h40);
    send_byte(8'h41);
  endtask

  // exactly full store, F7 overflowing it, data byte overflowing it
  task automatic test_long_sysex();
    int n;
    int i;
    for (n = SX_DEPTH - 2; n <= SX_DEPTH; n++) begin
      send_byte(MIDI_SYSEX_START);
      for (i = 0; i < n; i++) send_data();
      send_byte(MIDI_SYSEX_END);
    end
  endtask

  // receiver holds off while words keep coming, so the input backs up
  task automatic test_back_pressure();
    int i;
    hold_req = 1'b1;
    for (i = 0; i < 4; i++) send_real_time();
    sysex_msg(6);
    channel_msg(1);
  endtask

  task automatic test_random_traffic(input int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) random_sequence();
  endtask

  task automatic test_unthrottled_tail(input int count);
    quiet = 1'b1;
    test_random_traffic(count);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_words
    result_t got;
    result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {kind, status_byte, data_first, data_second, sysex_byte, last_of_run};
      if (got.kind == KIND_SYSEX) sysex_words++;
      else short_words++;
      if (parsed_words.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("%0t: unexpected word kind=%0d status=%h d1=%h d2=%h sysex=%h last=%0d",
                   $time, got.kind, got.status_byte, got.data_first, got.data_second,
                   got.sysex_byte, got.last_of_run);
        end
      end else begin
        want = parsed_words.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("%0t: word mismatch", $time);
            $display("  expected kind=%0d status=%h d1=%h d2=%h sysex=%h last=%0d",
                     want.kind, want.status_byte, want.data_first, want.data_second,
                     want.sysex_byte, want.last_of_run);
            $display("  actual   kind=%0d status=%h d1=%h d2=%h sysex=%h last=%0d",
                     got.kind, got.status_byte, got.data_first, got.data_second,
                     got.sysex_byte, got.last_of_run);
          end
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("midi_byte_stream_parser regression: fail");
    $finish;
  end

  initial begin : run_tests
    int waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_orphan_bytes();
    test_channel_messages();
    test_system_common();
    test_sysex_framing();
    test_long_sysex();
    test_back_pressure();
    test_random_traffic(16);
    test_unthrottled_tail(12);
    in_valid <= 1'b0;
    waited = 0;
    while (parsed_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (parsed_words.size() != 0) begin
      $display("%0d expected words never arrived", parsed_words.size());
      errors += parsed_words.size();
    end
    $display("fed %0d bytes (%0d acted on): running status, system common, SysEx framing,",
             bytes_sent, bytes_effective);
    $display("  store overflow and a long output hold; %0d short, %0d SysEx words (%0d runs), %0d errors",
             short_words, sysex_words, sysex_runs, errors);
    if (errors == 0) begin
      $display("midi_byte_stream_parser regression: pass");
    end else begin
      $display("midi_byte_stream_parser regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/mbsp_pkg.sv
hdl/mbsp_ctrl.sv
hdl/mbsp_datapath.sv
hdl/midi_byte_stream_parser.sv
test/midi_byte_stream_parser_test.sv
